// ----- rtl/bspz_pkg.sv -----
// bspz_pkg: shared types and constants of the BSP zone splitter.
// Used by bspz_ctrl, bspz_datapath and bsp_zone_splitter; no dependencies.
package bspz_pkg;

  localparam int DEF_MAX_WINDOWS     = 32;
  localparam int DEF_COORD_FRAC_BITS = 16;

  localparam int IN_W    = 6;   // window_count
  localparam int OUT_W   = 17;  // zone coordinates on the port
  localparam int RATIO_W = 16;  // Q0.16 split fraction

  localparam logic [RATIO_W-1:0] RATIO_LOW   = 16'd6554;   // 0.1
  localparam logic [RATIO_W-1:0] RATIO_HIGH  = 16'd58982;  // 0.9
  localparam logic [RATIO_W-1:0] RATIO_HALF  = 16'd32768;  // 0.5
  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd32768;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_READ,
    S_EVAL,
    S_NEAR,
    S_FAR
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;      // latch count and ratio, clear the queue
    logic push_root;  // write the whole square
    logic read;       // fetch the region at the head
    logic emit;       // leaf: pop and load the output register
    logic split;      // pop and multiply
    logic push_near;
    logic push_far;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_nonzero;  // saturated input count is not zero
    logic leaf;           // fetched region holds one window
    logic last_region;    // fetched region is the only one live
    logic out_busy;       // output register holds an item not yet taken
  } status_t;

endpackage

// ----- rtl/bspz_ctrl.sv -----
// bspz_ctrl: sequencer of the BSP zone splitter.
// Depends on bspz_pkg; drives cmd_t to bspz_datapath and reads status_t back.
module bspz_ctrl
  import bspz_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && status.count_nonzero) begin
          state_next = S_INIT;
        end
      end
      S_INIT: state_next = S_READ;
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        if (!status.leaf) begin
          state_next = S_NEAR;
        end else if (!status.out_busy) begin
          state_next = status.last_region ? S_IDLE : S_READ;
        end
      end
      S_NEAR: state_next = S_FAR;
      S_FAR:  state_next = S_READ;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_INIT: cmd.push_root = 1'b1;
      S_READ: cmd.read = 1'b1;
      S_EVAL: begin
        cmd.split = !status.leaf;
        cmd.emit  = status.leaf && !status.out_busy;
      end
      S_NEAR: cmd.push_near = 1'b1;
      S_FAR:  cmd.push_far = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/bspz_datapath.sv -----
// bspz_datapath: region queue, split arithmetic and output register.
// Depends on bspz_pkg; commanded by bspz_ctrl through cmd_t.
module bspz_datapath
  import bspz_pkg::*;
#(
  parameter int MAX_WINDOWS     = DEF_MAX_WINDOWS,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [RATIO_W-1:0] cfg_wr_data,
  input  logic               cfg_wr_en,
  input  logic [IN_W-1:0]    window_count,
  input  cmd_t               cmd,
  output status_t            status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OUT_W-1:0]   zone_x,
  output logic [OUT_W-1:0]   zone_y,
  output logic [OUT_W-1:0]   zone_w,
  output logic [OUT_W-1:0]   zone_h,
  output logic               last_zone
);

  localparam int COORD_W = COORD_FRAC_BITS + 1;
  localparam int IDX_W   = $clog2(MAX_WINDOWS);
  localparam int CNT_W   = $clog2(MAX_WINDOWS + 1);
  localparam int DEPTH_W = $clog2($clog2(MAX_WINDOWS) + 1);
  localparam int PROD_W  = COORD_W + RATIO_W;
  localparam int META_W  = DEPTH_W + CNT_W;

  localparam logic [COORD_W-1:0] ONE      = COORD_W'(1) << COORD_FRAC_BITS;
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(MAX_WINDOWS - 1);

  // region queue
  logic [2*COORD_W-1:0] origin_q [MAX_WINDOWS];
  logic [2*COORD_W-1:0] size_q   [MAX_WINDOWS];
  logic [META_W-1:0]    meta_q   [MAX_WINDOWS];

  logic [RATIO_W-1:0] master_ratio;
  logic [RATIO_W-1:0] ratio0;
  logic [CNT_W-1:0]   count_lat;
  logic [IDX_W-1:0]   head, tail;
  logic [CNT_W-1:0]   live;

  logic [COORD_W-1:0] rd_x, rd_y, rd_w, rd_h;
  logic [DEPTH_W-1:0] rd_depth;
  logic [CNT_W-1:0]   rd_count;
  logic [PROD_W-1:0]  prod;
  logic [COORD_W-1:0] split;

  logic [CNT_W-1:0]     count_sat;
  logic [RATIO_W-1:0]   ratio_clamped;
  logic                 horiz;
  logic [COORD_W-1:0]   sel_size, sel_origin, split_next;
  logic [RATIO_W-1:0]   sel_ratio;
  logic                 wr_en;
  logic [2*COORD_W-1:0] wr_origin, wr_size;
  logic [META_W-1:0]    wr_meta;
  logic [CNT_W-1:0]     near_n;

  always_comb begin
    if (int'(window_count) > MAX_WINDOWS) begin
      count_sat = CNT_W'(MAX_WINDOWS);
    end else begin
      count_sat = CNT_W'(window_count);
    end
    if (master_ratio < RATIO_LOW) begin
      ratio_clamped = RATIO_LOW;
    end else if (master_ratio > RATIO_HIGH) begin
      ratio_clamped = RATIO_HIGH;
    end else begin
      ratio_clamped = master_ratio;
    end
  end

  // odd depths cut horizontally
  assign horiz      = rd_depth[0];
  assign sel_size   = horiz ? rd_h : rd_w;
  assign sel_origin = horiz ? rd_y : rd_x;
  assign sel_ratio  = (rd_depth == '0) ? ratio0 : RATIO_HALF;
  assign split_next = COORD_W'(sel_origin + prod[PROD_W-1:RATIO_W]);
  assign near_n     = rd_count >> 1;

  always_comb begin
    wr_en     = cmd.push_root | cmd.push_near | cmd.push_far;
    wr_origin = {rd_x, rd_y};
    wr_size   = {rd_w, rd_h};
    wr_meta   = {DEPTH_W'(rd_depth + 1'b1), near_n};
    if (cmd.push_root) begin
      wr_origin = '0;
      wr_size   = {ONE, ONE};
      wr_meta   = {{DEPTH_W{1'b0}}, count_lat};
    end else if (cmd.push_near) begin
      if (horiz) begin
        wr_size = {rd_w, COORD_W'(split_next - rd_y)};
      end else begin
        wr_size = {COORD_W'(split_next - rd_x), rd_h};
      end
    end else if (cmd.push_far) begin
      wr_meta = {DEPTH_W'(rd_depth + 1'b1), CNT_W'(rd_count - near_n)};
      if (horiz) begin
        wr_origin = {rd_x, split};
        wr_size   = {rd_w, COORD_W'(rd_y + rd_h - split)};
      end else begin
        wr_origin = {split, rd_y};
        wr_size   = {COORD_W'(rd_x + rd_w - split), rd_h};
      end
    end
  end

  // queue memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      origin_q[tail] <= wr_origin;
      size_q[tail]   <= wr_size;
      meta_q[tail]   <= wr_meta;
    end
    if (cmd.read) begin
      {rd_x, rd_y}         <= origin_q[head];
      {rd_w, rd_h}         <= size_q[head];
      {rd_depth, rd_count} <= meta_q[head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.split) begin
      prod <= PROD_W'(sel_size) * PROD_W'(sel_ratio);
    end
    if (cmd.push_near) begin
      split <= split_next;
    end
    if (cmd.start) begin
      ratio0    <= ratio_clamped;
      count_lat <= count_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_ratio <= RATIO_RESET;
      head         <= '0;
      tail         <= '0;
      live         <= '0;
    end else begin
      if (cfg_wr_en) begin
        master_ratio <= cfg_wr_data;
      end
      if (cmd.start) begin
        head <= '0;
        tail <= '0;
        live <= '0;
      end else begin
        if (wr_en) begin
          tail <= (tail == LAST_IDX) ? '0 : IDX_W'(tail + 1'b1);
        end
        if (cmd.emit || cmd.split) begin
          head <= (head == LAST_IDX) ? '0 : IDX_W'(head + 1'b1);
        end
        if (wr_en && !(cmd.emit || cmd.split)) begin
          live <= CNT_W'(live + 1'b1);
        end else if (!wr_en && (cmd.emit || cmd.split)) begin
          live <= CNT_W'(live - 1'b1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      zone_x    <= OUT_W'(rd_x);
      zone_y    <= OUT_W'(rd_y);
      zone_w    <= OUT_W'(rd_w);
      zone_h    <= OUT_W'(rd_h);
      last_zone <= (live == CNT_W'(1));
    end
  end

  assign status.count_nonzero = (count_sat != '0);
  assign status.leaf          = (rd_count <= CNT_W'(1));
  assign status.last_region   = (live == CNT_W'(1));
  assign status.out_busy      = out_valid && !out_ready;

endmodule

// ----- rtl/bsp_zone_splitter.sv -----
// bsp_zone_splitter: top level, splits the unit square into zones by BSP.
// Depends on bspz_pkg, bspz_ctrl and bspz_datapath.
//
//   channel  handshake             payload
//   in       in_valid/in_ready     window_count
//   out      out_valid/out_ready   zone_x zone_y zone_w zone_h last_zone
//   cfg      cfg_wr_en             cfg_wr_data (master_ratio)
//
// For each region of a request the sequencer passes S_READ and S_EVAL;
// a split adds S_NEAR and S_FAR, as the region queue has a single write
// port (two pushes per split); S_READ comes first since its read is
// registered. A count of zero is accepted in S_IDLE and yields no zones.
// Reset is synchronous; the queue needs no clearing. A stalled output holds
// the sequencer on the next leaf; the next item is taken once the last zone
// is in the output register.
module bsp_zone_splitter
  import bspz_pkg::*;
#(
  parameter int MAX_WINDOWS     = DEF_MAX_WINDOWS,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [RATIO_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IN_W-1:0]    window_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OUT_W-1:0]   zone_x,
  output logic [OUT_W-1:0]   zone_y,
  output logic [OUT_W-1:0]   zone_w,
  output logic [OUT_W-1:0]   zone_h,
  output logic               last_zone
);

  cmd_t    cmd;
  status_t status;

  bspz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bspz_datapath #(
    .MAX_WINDOWS     (MAX_WINDOWS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_data  (cfg_wr_data),
    .cfg_wr_en    (cfg_wr_en),
    .window_count (window_count),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .zone_x       (zone_x),
    .zone_y       (zone_y),
    .zone_w       (zone_w),
    .zone_h       (zone_h),
    .last_zone    (last_zone)
  );

endmodule
